@@ design/ps2c_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2c_pkg
// Types, command codes and register indexes shared by the PS/2 command port.
// ----------------------------------------------------------------------------
package ps2c_pkg;

  // Configuration port geometry.
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] RegPortTwoPresent = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegPortOneCode    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegPortTwoCode    = 2'd2;

  // Controller commands.
  localparam logic [7:0] CmdReadConfig  = 8'h20;
  localparam logic [7:0] CmdWriteConfig = 8'h60;
  localparam logic [7:0] CmdSelfTest    = 8'hAA;
  localparam logic [7:0] CmdTestPortOne = 8'hAB;
  localparam logic [7:0] CmdTestPortTwo = 8'hA9;
  localparam logic [7:0] CmdDisPortOne  = 8'hAD;
  localparam logic [7:0] CmdEnPortOne   = 8'hAE;
  localparam logic [7:0] CmdDisPortTwo  = 8'hA7;
  localparam logic [7:0] CmdEnPortTwo   = 8'hA8;
  localparam logic [7:0] CmdWritePortTwo = 8'hD4;

  // Self test answer and reset value of the configuration byte.
  localparam logic [7:0] SelfTestPass  = 8'h55;
  localparam logic [7:0] ConfigReset   = 8'h30;

  // Configuration byte bit positions.
  localparam int CfgIrqOneBit = 0;
  localparam int CfgIrqTwoBit = 1;
  localparam int CfgSysBit    = 2;
  localparam int CfgClkOneBit = 4;
  localparam int CfgClkTwoBit = 5;

  // Request kinds.
  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_DEVICE = 2'd2
  } mode_e;

  // Pending command after a command write.
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_CFG   = 2'd1,
    PEND_PORT2 = 2'd2
  } pend_e;

  // Configuration registers as seen by the core.
  typedef struct packed {
    logic       port_two_present;
    logic [7:0] port_one_test_code;
    logic [7:0] port_two_test_code;
    logic       force_clk_two;
  } cfg_t;

  // One request.
  typedef struct packed {
    logic [1:0] mode;
    logic       addr_is_command;
    logic [7:0] host_byte;
    logic       from_port_two;
    logic [7:0] device_byte;
  } req_t;

  // One response.
  typedef struct packed {
    logic [7:0] read_data;
    logic       send_valid;
    logic       send_to_port_two;
    logic [7:0] send_byte;
    logic       device_refused;
    logic       irq_one;
    logic       irq_two;
  } rsp_t;

endpackage

@@ design/ps2c_req_if.sv @@
// ----------------------------------------------------------------------------
// ps2c_req_if
// Request channel: host accesses and device bytes, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ps2c_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       addr_is_command;
  logic [7:0] host_byte;
  logic       from_port_two;
  logic [7:0] device_byte;

  modport source (
    output valid, mode, addr_is_command, host_byte, from_port_two, device_byte,
    input  ready
  );

  modport sink (
    input  valid, mode, addr_is_command, host_byte, from_port_two, device_byte,
    output ready
  );
endinterface

@@ design/ps2c_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ps2c_rsp_if
// Response channel: one response per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ps2c_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       send_valid;
  logic       send_to_port_two;
  logic [7:0] send_byte;
  logic       device_refused;
  logic       irq_one;
  logic       irq_two;

  modport source (
    output valid, read_data, send_valid, send_to_port_two, send_byte,
           device_refused, irq_one, irq_two,
    input  ready
  );

  modport sink (
    input  valid, read_data, send_valid, send_to_port_two, send_byte,
           device_refused, irq_one, irq_two,
    output ready
  );
endinterface

@@ design/ps2c_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ps2c_cfg_regs
// Configuration registers and the clock-two fixup request for one channel.
// ----------------------------------------------------------------------------
module ps2c_cfg_regs
  import ps2c_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  output cfg_t                    cfg_o
);

  logic       dual_q, dual_d;
  logic [7:0] code_one_q, code_one_d;
  logic [7:0] code_two_q, code_two_d;
  logic       fix_q, fix_d;

  // Register decode. Every write, whatever the index, asks the core to keep
  // the clock of port two disabled when there is no second port.
  always_comb begin
    dual_d     = dual_q;
    code_one_d = code_one_q;
    code_two_d = code_two_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPortTwoPresent: dual_d     = cfg_wdata_i[0];
        RegPortOneCode:    code_one_d = cfg_wdata_i;
        RegPortTwoCode:    code_two_d = cfg_wdata_i;
        default:           ;
      endcase
    end
    fix_d = cfg_we_i && !dual_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dual_q     <= 1'b1;
      code_one_q <= '0;
      code_two_q <= '0;
      fix_q      <= 1'b0;
    end else begin
      dual_q     <= dual_d;
      code_one_q <= code_one_d;
      code_two_q <= code_two_d;
      fix_q      <= fix_d;
    end
  end

  assign cfg_o.port_two_present   = dual_q;
  assign cfg_o.port_one_test_code = code_one_q;
  assign cfg_o.port_two_test_code = code_two_q;
  assign cfg_o.force_clk_two      = fix_q;

endmodule

@@ design/ps2c_core.sv @@
// ----------------------------------------------------------------------------
// ps2c_core
// Request register, controller state and the single-pass request decode.
// ----------------------------------------------------------------------------
module ps2c_core
  import ps2c_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  logic       stage_valid_q;
  req_t       stage_q;
  logic       take;

  logic [7:0] config_q, config_d;
  logic [7:0] buf_q, buf_d;
  logic       full_q, full_d;
  logic       aux_q, aux_d;
  pend_e      pend_q, pend_d;
  rsp_t       res;
  logic [7:0] status;
  logic       clk_off;

  // The staged request moves on when the result register can take it.
  assign take        = stage_valid_q && rsp_ready_i;
  assign req_ready_o = !stage_valid_q || rsp_ready_i;
  assign rsp_valid_o = stage_valid_q;
  assign rsp_o       = res;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      stage_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      stage_q <= req_i;
    end
  end

  // Status byte: input buffer never full, not inhibited, no errors.
  assign status = {2'b00, full_q && aux_q, 1'b1, 1'b0, config_q[CfgSysBit], 1'b0, full_q};

  assign clk_off = stage_q.from_port_two ? config_q[CfgClkTwoBit] : config_q[CfgClkOneBit];

  // Request decode and next state.
  always_comb begin
    config_d = config_q;
    buf_d    = buf_q;
    full_d   = full_q;
    aux_d    = aux_q;
    pend_d   = pend_q;
    res      = '0;
    case (mode_e'(stage_q.mode))
      MODE_READ: begin
        if (stage_q.addr_is_command) begin
          res.read_data = status;
        end else begin
          res.read_data = buf_q;
          full_d        = 1'b0;
          aux_d         = 1'b0;
        end
      end
      MODE_WRITE: begin
        pend_d = PEND_NONE;
        if (stage_q.addr_is_command) begin
          // Controller commands; answers overwrite the buffer.
          unique case (stage_q.host_byte)
            CmdReadConfig: begin
              buf_d  = config_q;
              full_d = 1'b1;
              aux_d  = 1'b0;
            end
            CmdWriteConfig: pend_d = PEND_CFG;
            CmdSelfTest: begin
              buf_d               = SelfTestPass;
              full_d              = 1'b1;
              aux_d               = 1'b0;
              config_d[CfgSysBit] = 1'b1;
            end
            CmdTestPortOne: begin
              buf_d  = cfg_i.port_one_test_code;
              full_d = 1'b1;
              aux_d  = 1'b0;
            end
            CmdTestPortTwo: begin
              if (cfg_i.port_two_present) begin
                buf_d  = cfg_i.port_two_test_code;
                full_d = 1'b1;
                aux_d  = 1'b0;
              end
            end
            CmdDisPortOne: config_d[CfgClkOneBit] = 1'b1;
            CmdEnPortOne:  config_d[CfgClkOneBit] = 1'b0;
            CmdDisPortTwo: begin
              if (cfg_i.port_two_present) config_d[CfgClkTwoBit] = 1'b1;
            end
            CmdEnPortTwo: begin
              if (cfg_i.port_two_present) config_d[CfgClkTwoBit] = 1'b0;
            end
            CmdWritePortTwo: begin
              if (cfg_i.port_two_present) pend_d = PEND_PORT2;
            end
            default: ;
          endcase
        end else begin
          // Data port write: finish a pending command or send to port one.
          case (pend_q)
            PEND_CFG: begin
              config_d = stage_q.host_byte;
              if (!cfg_i.port_two_present) config_d[CfgClkTwoBit] = 1'b1;
            end
            PEND_PORT2: begin
              if (cfg_i.port_two_present) begin
                res.send_valid       = 1'b1;
                res.send_to_port_two = 1'b1;
                res.send_byte        = stage_q.host_byte;
              end
            end
            default: begin
              res.send_valid = 1'b1;
              res.send_byte  = stage_q.host_byte;
            end
          endcase
        end
      end
      MODE_DEVICE: begin
        if ((stage_q.from_port_two && !cfg_i.port_two_present) || full_q || clk_off) begin
          res.device_refused = 1'b1;
        end else begin
          buf_d  = stage_q.device_byte;
          full_d = 1'b1;
          aux_d  = stage_q.from_port_two;
          if (stage_q.from_port_two) begin
            res.irq_two = config_q[CfgIrqTwoBit];
          end else begin
            res.irq_one = config_q[CfgIrqOneBit];
          end
        end
      end
      default: ;
    endcase
  end

  // Controller state. The clock-two fixup after a configuration write wins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      config_q <= ConfigReset;
      buf_q    <= '0;
      full_q   <= 1'b0;
      aux_q    <= 1'b0;
      pend_q   <= PEND_NONE;
    end else begin
      if (take) begin
        config_q <= config_d;
        buf_q    <= buf_d;
        full_q   <= full_d;
        aux_q    <= aux_d;
        pend_q   <= pend_d;
      end
      if (cfg_i.force_clk_two) begin
        config_q[CfgClkTwoBit] <= 1'b1;
      end
    end
  end

  // Without a second port its clock stays disabled once the fixup is done.
  a_clk_two_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_i.port_two_present && !cfg_i.force_clk_two) |-> config_q[CfgClkTwoBit])
    else $error("port two clock enabled on a single channel controller");

  // The auxiliary flag only ever marks a full buffer.
  a_aux_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aux_q |-> full_q)
    else $error("auxiliary flag set with an empty output buffer");

  // An interrupt pulse always comes with a buffered device byte.
  a_irq_buffered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (res.irq_one || res.irq_two)) |=> full_q)
    else $error("interrupt raised without a buffered byte");

endmodule

@@ design/ps2c_out_reg.sv @@
// ----------------------------------------------------------------------------
// ps2c_out_reg
// Response register between the core and the response channel.
// ----------------------------------------------------------------------------
module ps2c_out_reg
  import ps2c_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rsp_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  logic valid_q;
  rsp_t data_q;

  // Take a new response when empty or when the held one leaves.
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ design/ps2_controller_command_port_unit.sv @@
// ----------------------------------------------------------------------------
// ps2_controller_command_port_unit
// Controller side of a two-port PS/2 host interface, command and data ports.
// ----------------------------------------------------------------------------
// Usage: each request on req_i is a host read, a host write to the data or
// command port, or a byte received from a device. Every request yields
// exactly one response on rsp_o, in order: read data or status, a byte to
// send to a device, a refusal flag for device bytes and interrupt pulses.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) sets whether
// port two exists and the two port test answers; write it while no
// request is in flight.
// A request passes through the request register, where the decode and the
// state update happen, and then the response register before its response
// is valid. Throughput is one request per cycle while the receiver does
// not stall, since the controller state updates in the same single pass.
// Reset clears the output buffer and pending command, loads the
// configuration byte with both port clocks disabled, and marks port two
// as present. When the receiver stalls, the response register holds
// its value and the request register behind it fills; then req_i.ready drops.
// ----------------------------------------------------------------------------
module ps2_controller_command_port_unit
  import ps2c_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  ps2c_req_if.sink                req_i,
  ps2c_rsp_if.source              rsp_o
);

  cfg_t cfg;
  req_t req;
  rsp_t core_rsp;
  rsp_t out_rsp;
  logic core_valid;
  logic core_ready;

  // Request fields into one word.
  assign req.mode            = req_i.mode;
  assign req.addr_is_command = req_i.addr_is_command;
  assign req.host_byte       = req_i.host_byte;
  assign req.from_port_two   = req_i.from_port_two;
  assign req.device_byte     = req_i.device_byte;

  ps2c_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  ps2c_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .req_i      (req),
    .rsp_valid_o(core_valid),
    .rsp_ready_i(core_ready),
    .rsp_o      (core_rsp)
  );

  ps2c_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (core_valid),
    .in_ready_o (core_ready),
    .in_data_i  (core_rsp),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .out_data_o (out_rsp)
  );

  // Response word onto the channel.
  assign rsp_o.read_data        = out_rsp.read_data;
  assign rsp_o.send_valid       = out_rsp.send_valid;
  assign rsp_o.send_to_port_two = out_rsp.send_to_port_two;
  assign rsp_o.send_byte        = out_rsp.send_byte;
  assign rsp_o.device_refused   = out_rsp.device_refused;
  assign rsp_o.irq_one          = out_rsp.irq_one;
  assign rsp_o.irq_two          = out_rsp.irq_two;

endmodule

@@ test/ps2c_response_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2c_response_checker
// Watches the request, response and configuration ports of the PS/2 command
// port, keeps its own copy of the controller state, works out the response
// that every accepted request must produce and compares each accepted
// response with the oldest one still owed.
// ----------------------------------------------------------------------------
module ps2c_response_checker
  import ps2c_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  ps2c_req_if                     req_i,
  ps2c_rsp_if                     rsp_i,
  output int                      err_count_o,
  output int                      owed_count_o
);

  localparam int ShowLimit = 10;

  // Register copies.
  logic       dual_q;
  logic [7:0] code_one_q;
  logic [7:0] code_two_q;

  // Controller state copies.
  logic [7:0] ctrl_cfg_q;
  logic [7:0] obuf_q;
  logic       obuf_full_q;
  logic       obuf_aux_q;
  pend_e      pend_q;

  // Responses the controller still owes, oldest first.
  rsp_t owed_rsp_q[$];
  int   err_cnt;
  int   shown_cnt;
  req_t seen_req;
  rsp_t seen_rsp;
  rsp_t want_rsp;

  // Without a second port the clock of port two stays disabled.
  function automatic logic [7:0] keep_clk_two(logic [7:0] v);
    if (!dual_q) v[CfgClkTwoBit] = 1'b1;
    return v;
  endfunction

  // A controller answer takes the buffer, even when it is full.
  function automatic void load_answer(logic [7:0] v);
    obuf_q      = v;
    obuf_full_q = 1'b1;
    obuf_aux_q  = 1'b0;
  endfunction

  function automatic logic [7:0] status_value();
    logic [7:0] s;
    s = 8'h10;
    s[0] = obuf_full_q;
    s[CfgSysBit] = ctrl_cfg_q[CfgSysBit];
    s[5] = obuf_full_q & obuf_aux_q;
    return s;
  endfunction

  // Command port write; any command cancels a pending one.
  function automatic void run_command(logic [7:0] c);
    pend_q = PEND_NONE;
    case (c)
      CmdReadConfig:   load_answer(ctrl_cfg_q);
      CmdWriteConfig:  pend_q = PEND_CFG;
      CmdSelfTest: begin
        load_answer(SelfTestPass);
        ctrl_cfg_q[CfgSysBit] = 1'b1;
      end
      CmdTestPortOne:  load_answer(code_one_q);
      CmdTestPortTwo:  if (dual_q) load_answer(code_two_q);
      CmdDisPortOne:   ctrl_cfg_q[CfgClkOneBit] = 1'b1;
      CmdEnPortOne:    ctrl_cfg_q[CfgClkOneBit] = 1'b0;
      CmdDisPortTwo:   if (dual_q) ctrl_cfg_q[CfgClkTwoBit] = 1'b1;
      CmdEnPortTwo:    if (dual_q) ctrl_cfg_q[CfgClkTwoBit] = 1'b0;
      CmdWritePortTwo: if (dual_q) pend_q = PEND_PORT2;
      default: ;
    endcase
  endfunction

  // One request through the controller: updates the state copy and
  // returns the response it causes.
  function automatic rsp_t controller_step(req_t r);
    rsp_t  o;
    pend_e p;
    int    clk_bit;
    o = '0;
    case (r.mode)
      MODE_READ: begin
        if (r.addr_is_command) begin
          o.read_data = status_value();
        end else begin
          o.read_data = obuf_q;
          obuf_full_q = 1'b0;
          obuf_aux_q  = 1'b0;
        end
      end
      MODE_WRITE: begin
        if (r.addr_is_command) begin
          run_command(r.host_byte);
        end else begin
          p = pend_q;
          pend_q = PEND_NONE;
          case (p)
            PEND_CFG: ctrl_cfg_q = keep_clk_two(r.host_byte);
            PEND_PORT2: begin
              if (dual_q) begin
                o.send_valid       = 1'b1;
                o.send_to_port_two = 1'b1;
                o.send_byte        = r.host_byte;
              end
            end
            default: begin
              o.send_valid = 1'b1;
              o.send_byte  = r.host_byte;
            end
          endcase
        end
      end
      MODE_DEVICE: begin
        clk_bit = r.from_port_two ? CfgClkTwoBit : CfgClkOneBit;
        if ((r.from_port_two && !dual_q) || obuf_full_q || ctrl_cfg_q[clk_bit]) begin
          o.device_refused = 1'b1;
        end else begin
          obuf_q      = r.device_byte;
          obuf_full_q = 1'b1;
          obuf_aux_q  = r.from_port_two;
          if (r.from_port_two) o.irq_two = ctrl_cfg_q[CfgIrqTwoBit];
          else                 o.irq_one = ctrl_cfg_q[CfgIrqOneBit];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Track configuration writes and requests, and check responses.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dual_q      = 1'b1;
      code_one_q  = 8'h00;
      code_two_q  = 8'h00;
      ctrl_cfg_q  = ConfigReset;
      obuf_q      = 8'h00;
      obuf_full_q = 1'b0;
      obuf_aux_q  = 1'b0;
      pend_q      = PEND_NONE;
      owed_rsp_q.delete();
      err_cnt     = 0;
      shown_cnt   = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        seen_rsp.read_data        = rsp_i.read_data;
        seen_rsp.send_valid       = rsp_i.send_valid;
        seen_rsp.send_to_port_two = rsp_i.send_to_port_two;
        seen_rsp.send_byte        = rsp_i.send_byte;
        seen_rsp.device_refused   = rsp_i.device_refused;
        seen_rsp.irq_one          = rsp_i.irq_one;
        seen_rsp.irq_two          = rsp_i.irq_two;
        if (owed_rsp_q.size() == 0) begin
          err_cnt++;
          if (shown_cnt < ShowLimit) begin
            shown_cnt++;
            $display("[%0t] response with no request outstanding: read_data %02h",
                     $time, seen_rsp.read_data);
          end
        end else begin
          want_rsp = owed_rsp_q.pop_front();
          if (seen_rsp.read_data !== want_rsp.read_data ||
              seen_rsp.send_valid !== want_rsp.send_valid ||
              seen_rsp.send_to_port_two !== want_rsp.send_to_port_two ||
              seen_rsp.send_byte !== want_rsp.send_byte ||
              seen_rsp.device_refused !== want_rsp.device_refused ||
              seen_rsp.irq_one !== want_rsp.irq_one ||
              seen_rsp.irq_two !== want_rsp.irq_two) begin
            err_cnt++;
            if (shown_cnt < ShowLimit) begin
              shown_cnt++;
              $display("[%0t] response mismatch (expected / actual):", $time);
              $display("  read_data %02h / %02h  send %b%b %02h / %b%b %02h",
                       want_rsp.read_data, seen_rsp.read_data,
                       want_rsp.send_valid, want_rsp.send_to_port_two,
                       want_rsp.send_byte, seen_rsp.send_valid,
                       seen_rsp.send_to_port_two, seen_rsp.send_byte);
              $display("  refused %b / %b  irq %b%b / %b%b",
                       want_rsp.device_refused, seen_rsp.device_refused,
                       want_rsp.irq_one, want_rsp.irq_two,
                       seen_rsp.irq_one, seen_rsp.irq_two);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPortTwoPresent: dual_q     = cfg_wdata_i[0];
          RegPortOneCode:    code_one_q = cfg_wdata_i;
          RegPortTwoCode:    code_two_q = cfg_wdata_i;
          default: ;
        endcase
        ctrl_cfg_q = keep_clk_two(ctrl_cfg_q);
      end
      if (req_i.valid && req_i.ready) begin
        seen_req.mode            = req_i.mode;
        seen_req.addr_is_command = req_i.addr_is_command;
        seen_req.host_byte       = req_i.host_byte;
        seen_req.from_port_two   = req_i.from_port_two;
        seen_req.device_byte     = req_i.device_byte;
        owed_rsp_q.push_back(controller_step(seen_req));
      end
    end
    err_count_o  <= err_cnt;
    owed_count_o <= owed_rsp_q.size();
  end

endmodule

@@ test/ps2_controller_command_port_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_controller_command_port_unit_tb
// Drives host reads, host writes and device bytes into the PS/2 command
// port: a directed pass over every command and corner case, then random
// phases under several register settings with random gaps on both sides,
// a long response hold-off and a gap-free stretch. A checker module beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module ps2_controller_command_port_unit_tb;
  import ps2c_pkg::*;

  localparam int         GapPercent  = 8;
  localparam int         HoldCycles  = 64;
  localparam int         PhaseItems  = 150;
  localparam int         LimitCycles = 200000;
  localparam logic [1:0] ModeUnused  = 2'd3;
  localparam logic       PortData    = 1'b0;
  localparam logic       PortCmd     = 1'b1;
  localparam logic       SrcOne      = 1'b0;
  localparam logic       SrcTwo      = 1'b1;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_idx;
  logic [CfgDataWidth-1:0] cfg_wdata;
  bit                      no_gaps;
  bit                      hold_rsp;
  int                      err_count;
  int                      owed_count;
  int                      sent_items;

  ps2c_req_if req_if ();
  ps2c_rsp_if rsp_if ();

  ps2_controller_command_port_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  ps2c_response_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .err_count_o  (err_count),
    .owed_count_o (owed_count)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #(LimitCycles * 10);
    $display("ps2_controller_command_port_unit_tb: done, errors");
    $finish;
  end

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        hold_rsp     <= 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      rsp_if.ready <= no_gaps || ($urandom_range(99) >= GapPercent);
    end
  end

  // A request with random content in every field but the mode.
  function automatic req_t rand_req(logic [1:0] m);
    req_t r;
    r.mode            = m;
    r.addr_is_command = 1'($urandom_range(1));
    r.host_byte       = 8'($urandom);
    r.from_port_two   = 1'($urandom_range(1));
    r.device_byte     = 8'($urandom);
    return r;
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(9))
      0:       return CmdReadConfig;
      1:       return CmdWriteConfig;
      2:       return CmdSelfTest;
      3:       return CmdTestPortOne;
      4:       return CmdTestPortTwo;
      5:       return CmdDisPortOne;
      6:       return CmdEnPortOne;
      7:       return CmdDisPortTwo;
      8:       return CmdEnPortTwo;
      default: return CmdWritePortTwo;
    endcase
  endfunction

  // Configuration bytes mostly keep both port clocks running.
  function automatic logic [7:0] rand_cfg_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(3) != 0) begin
      v[CfgClkOneBit] = 1'b0;
      v[CfgClkTwoBit] = 1'b0;
    end
    return v;
  endfunction

  // Offer one request and wait until it is taken.
  task automatic push_req(req_t r);
    while (!no_gaps && $urandom_range(99) < GapPercent) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.mode            <= r.mode;
    req_if.addr_is_command <= r.addr_is_command;
    req_if.host_byte       <= r.host_byte;
    req_if.from_port_two   <= r.from_port_two;
    req_if.device_byte     <= r.device_byte;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic host_read(logic is_cmd);
    req_t r;
    r = rand_req(MODE_READ);
    r.addr_is_command = is_cmd;
    push_req(r);
  endtask

  task automatic host_write(logic is_cmd, logic [7:0] b);
    req_t r;
    r = rand_req(MODE_WRITE);
    r.addr_is_command = is_cmd;
    r.host_byte = b;
    push_req(r);
  endtask

  task automatic dev_byte(logic p2, logic [7:0] b);
    req_t r;
    r = rand_req(MODE_DEVICE);
    r.from_port_two = p2;
    r.device_byte = b;
    push_req(r);
  endtask

  // Stop offering and wait until every owed response has arrived.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic dual, logic [7:0] code_one, logic [7:0] code_two);
    drain();
    write_reg(RegPortTwoPresent, {7'd0, dual});
    write_reg(RegPortOneCode, code_one);
    write_reg(RegPortTwoCode, code_two);
  endtask

  // One short random sequence, mostly well formed.
  task automatic random_burst();
    int         pick;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 20) begin
      host_read(1'($urandom_range(1)));
    end else if (pick < 38) begin
      dev_byte(1'($urandom_range(1)), 8'($urandom));
    end else if (pick < 55) begin
      c = pick_command();
      host_write(PortCmd, c);
      if ($urandom_range(9) < 8) begin
        if (c == CmdWriteConfig) host_write(PortData, rand_cfg_byte());
        else if (c == CmdWritePortTwo) host_write(PortData, 8'($urandom));
      end
    end else if (pick < 65) begin
      dev_byte(1'($urandom_range(1)), 8'($urandom));
      host_read(PortData);
    end else if (pick < 75) begin
      host_write(PortCmd, CmdEnPortOne);
      host_write(PortCmd, CmdEnPortTwo);
    end else if (pick < 85) begin
      host_write(PortData, 8'($urandom));
    end else if (pick < 93) begin
      host_write(PortCmd, CmdWriteConfig);
      host_write(PortData, rand_cfg_byte());
    end else begin
      case ($urandom_range(2))
        0:       host_write(PortCmd, 8'($urandom));
        1:       push_req(rand_req(ModeUnused));
        default: push_req(rand_req(2'($urandom_range(2))));
      endcase
    end
  endtask

  task automatic random_items(int n);
    int target;
    target = sent_items + n;
    while (sent_items < target) random_burst();
  endtask

  // Stimulus and verdict.
  initial begin
    req_if.valid           <= 1'b0;
    req_if.mode            <= MODE_READ;
    req_if.addr_is_command <= 1'b0;
    req_if.host_byte       <= 8'h00;
    req_if.from_port_two   <= 1'b0;
    req_if.device_byte     <= 8'h00;
    cfg_we                 <= 1'b0;
    cfg_idx                <= RegPortTwoPresent;
    cfg_wdata              <= '0;
    no_gaps                <= 1'b0;
    hold_rsp               <= 1'b0;
    sent_items              = 0;
    rst_n                   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Status and a stale read from an empty buffer, then a byte on a
    // disabled port.
    host_read(PortCmd);
    host_read(PortData);
    dev_byte(SrcOne, 8'hA5);
    host_write(PortCmd, CmdEnPortOne);
    host_write(PortCmd, CmdEnPortTwo);
    // Buffered byte, then a refusal because the buffer is full.
    dev_byte(SrcOne, 8'hFF);
    dev_byte(SrcTwo, 8'h00);
    host_read(PortCmd);
    host_read(PortData);
    dev_byte(SrcTwo, 8'h00);
    host_read(PortCmd);
    // Interrupts enabled; an answer overwrites a full buffer.
    host_write(PortCmd, CmdWriteConfig);
    host_write(PortData, 8'h03);
    dev_byte(SrcOne, 8'h5A);
    host_write(PortCmd, CmdTestPortOne);
    host_read(PortData);
    dev_byte(SrcTwo, 8'hC3);
    host_write(PortCmd, CmdReadConfig);
    host_write(PortCmd, CmdSelfTest);
    host_read(PortCmd);
    host_read(PortData);
    host_write(PortCmd, CmdTestPortTwo);
    host_read(PortData);
    // Port two write, plain write, and a pending command cancelled.
    host_write(PortCmd, CmdWritePortTwo);
    host_write(PortData, 8'hFF);
    host_write(PortData, 8'h00);
    host_write(PortCmd, CmdWriteConfig);
    host_write(PortCmd, 8'h00);
    host_write(PortData, 8'h81);
    push_req(rand_req(ModeUnused));
    host_write(PortCmd, CmdDisPortOne);
    host_write(PortCmd, CmdDisPortTwo);
    host_read(PortData);
    dev_byte(SrcOne, 8'h11);

    // Test answers at their top value, and a port two write left pending
    // while the second port is removed.
    set_regs(1'b1, 8'hFF, 8'hFF);
    host_write(PortCmd, CmdTestPortOne);
    host_read(PortData);
    host_write(PortCmd, CmdTestPortTwo);
    host_read(PortData);
    host_write(PortCmd, CmdWritePortTwo);
    drain();
    write_reg(RegPortTwoPresent, 8'h00);
    host_write(PortData, 8'h3C);
    // Single channel: port two commands ignored, port two bytes refused.
    host_write(PortCmd, CmdTestPortTwo);
    host_write(PortCmd, CmdEnPortTwo);
    host_write(PortCmd, CmdWritePortTwo);
    host_write(PortData, 8'hC3);
    host_write(PortCmd, CmdEnPortOne);
    dev_byte(SrcTwo, 8'h77);
    host_write(PortCmd, CmdWriteConfig);
    host_write(PortData, 8'h00);
    host_write(PortCmd, CmdReadConfig);
    host_read(PortData);

    // Random phases under several register settings.
    set_regs(1'b1, 8'h00, 8'h00);
    random_items(PhaseItems);

    // Long response hold-off while requests keep coming.
    set_regs(1'b1, 8'($urandom), 8'($urandom));
    hold_rsp <= 1'b1;
    no_gaps  <= 1'b1;
    random_items(20);
    no_gaps  <= 1'b0;
    random_items(PhaseItems - 20);

    // Gap-free stretch on both sides.
    set_regs(1'b0, 8'hFF, 8'h00);
    no_gaps <= 1'b1;
    random_items(PhaseItems);
    no_gaps <= 1'b0;

    set_regs(1'b1, 8'h00, 8'hFF);
    random_items(PhaseItems);

    set_regs(1'b0, 8'($urandom), 8'($urandom));
    random_items(PhaseItems);

    drain();
    if (err_count == 0 && owed_count == 0) begin
      $display("ps2_controller_command_port_unit_tb: done, clean");
    end else begin
      $display("ps2_controller_command_port_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
